@@ rtl/core/tdf_pkg.sv @@
// Shared constants and controller/datapath interface types for the trial division factorizer.
package tdf_pkg;

	localparam int WIDTH = 32;
	localparam int IN_W = 32;
	localparam int OUT_W = 32;
	localparam int DW = (WIDTH < IN_W) ? WIDTH : IN_W;
	localparam int CW = DW / 2 + 1;
	localparam int SW = 2 * CW;
	localparam int NW = 6;
	localparam int CNT_W = $clog2(DW + 1);
	localparam int MAX_RESULTS = 32;
	localparam int FIRST_CAND = 2;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic take_factor;
		logic take_rem;
		logic next_cand;
		logic push_last;
		logic push_none;
	} cmd_t;

	typedef struct packed {
		logic v_le1;
		logic sq_le_v;
		logic div_busy;
		logic rem_zero;
		logic r_le1;
		logic n_full;
		logic pend_valid;
		logic slot_free;
	} sts_t;

endpackage

@@ rtl/core/tdf_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tdf_div
	import tdf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient,
	output logic [CW-1:0] remainder
);

	logic [DW-1:0]    q_q;
	logic [CW-1:0]    rm_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [CW:0]      trial;
	logic [CW:0]      diff;
	logic             ge;

	assign trial = {rm_q, q_q[DW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend;
			rm_q <= '0;
		end else if (busy_q) begin
			q_q  <= {q_q[DW-2:0], ge};
			rm_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = q_q;
	assign remainder = rm_q;

endmodule

@@ rtl/core/tdf_dp.sv @@
// Datapath: value, remainder, candidate, square bound, pending factor and output register.
module tdf_dp
	import tdf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [IN_W-1:0]  value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] factor,
	output logic [NW-1:0]    factor_index,
	output logic             is_last,
	output logic             no_factor
);

	logic [DW-1:0]    v_q;
	logic [DW-1:0]    r_q;
	logic [CW-1:0]    c_q;
	logic [SW-1:0]    sq_q;
	logic [NW-1:0]    n_q;
	logic             pv_q;
	logic [DW-1:0]    pf_q;
	logic [NW-1:0]    pidx_q;
	logic             ov_q;
	logic [OUT_W-1:0] factor_q;
	logic [NW-1:0]    idx_q;
	logic             last_q;
	logic             none_q;
	logic             div_busy;
	logic [DW-1:0]    quot;
	logic [CW-1:0]    rem;
	logic             push;

	tdf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (r_q),
		.divisor   (c_q),
		.busy      (div_busy),
		.quotient  (quot),
		.remainder (rem)
	);

	assign push = cmd.push_last || cmd.push_none ||
		((cmd.take_factor || cmd.take_rem) && pv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			ov_q <= 1'b0;
			n_q  <= '0;
		end else begin
			if (cmd.load_in) begin
				pv_q <= 1'b0;
				n_q  <= '0;
			end else if (cmd.take_factor || cmd.take_rem) begin
				pv_q <= 1'b1;
				n_q  <= n_q + NW'(1);
			end
			if (push) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			v_q  <= value[DW-1:0];
			r_q  <= value[DW-1:0];
			c_q  <= CW'(FIRST_CAND);
			sq_q <= SW'(1);
		end
		if (cmd.next_cand) begin
			c_q  <= c_q + CW'(1);
			sq_q <= sq_q + SW'({c_q, 1'b0}) - SW'(1);
		end
		if (cmd.take_factor) begin
			r_q    <= quot;
			pf_q   <= DW'(c_q);
			pidx_q <= n_q + NW'(1);
		end
		if (cmd.take_rem) begin
			pf_q   <= r_q;
			pidx_q <= n_q + NW'(1);
		end
		if (cmd.push_none) begin
			factor_q <= '0;
			idx_q    <= '0;
			last_q   <= 1'b1;
			none_q   <= 1'b1;
		end else if (push) begin
			factor_q <= OUT_W'(pf_q);
			idx_q    <= pidx_q;
			last_q   <= cmd.push_last;
			none_q   <= 1'b0;
		end
	end

	assign sts.v_le1      = v_q <= DW'(1);
	assign sts.sq_le_v    = sq_q <= SW'(v_q);
	assign sts.div_busy   = div_busy;
	assign sts.rem_zero   = rem == '0;
	assign sts.r_le1      = r_q <= DW'(1);
	assign sts.n_full     = n_q >= NW'(MAX_RESULTS);
	assign sts.pend_valid = pv_q;
	assign sts.slot_free  = !ov_q || out_ready;

	assign out_valid    = ov_q;
	assign factor       = factor_q;
	assign factor_index = idx_q;
	assign is_last      = last_q;
	assign no_factor    = none_q;

endmodule

@@ rtl/core/tdf_ctrl.sv @@
// Controller state machine sequencing candidates, divisions and result pushes.
module tdf_ctrl
	import tdf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		DIV,
		FINAL,
		LAST,
		NONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = CHECK;
				end
			end
			CHECK: begin
				if (sts.v_le1) begin
					state_d = NONE;
				end else if (sts.sq_le_v) begin
					cmd.div_start = 1'b1;
					state_d       = DIV;
				end else begin
					state_d = FINAL;
				end
			end
			DIV: begin
				if (!sts.div_busy) begin
					if (sts.rem_zero && !sts.n_full) begin
						if (!sts.pend_valid || sts.slot_free) begin
							cmd.take_factor = 1'b1;
							state_d         = CHECK;
						end
					end else if (sts.r_le1 || sts.n_full) begin
						state_d = FINAL;
					end else begin
						cmd.next_cand = 1'b1;
						state_d       = CHECK;
					end
				end
			end
			FINAL: begin
				if (!sts.r_le1 && !sts.n_full) begin
					if (!sts.pend_valid || sts.slot_free) begin
						cmd.take_rem = 1'b1;
						state_d      = LAST;
					end
				end else begin
					state_d = LAST;
				end
			end
			LAST: begin
				if (sts.slot_free) begin
					cmd.push_last = 1'b1;
					state_d       = IDLE;
				end
			end
			NONE: begin
				if (sts.slot_free) begin
					cmd.push_none = 1'b1;
					state_d       = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/trial_division_factorizer.sv @@
// Top level of the trial division factorizer: controller plus datapath.
// Takes one unsigned value per item and returns its prime factors in ascending
// order, repeats included, one result item per factor, the final one flagged
// is_last; 0 and 1 give a single result with no_factor set. A new value is
// taken only once the previous one has been fully factored; the last result
// may still sit in the output register. Each candidate divisor costs one pass
// of the bit-serial divider, and each factor found costs one more pass, so the
// work per item grows with the candidates tried plus the factors found; for
// a 32-bit prime the candidates run up to 65536.
module trial_division_factorizer
	import tdf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [IN_W-1:0]  value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] factor,
	output logic [NW-1:0]    factor_index,
	output logic             is_last,
	output logic             no_factor
);

	cmd_t cmd;
	sts_t sts;

	tdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.factor       (factor),
		.factor_index (factor_index),
		.is_last      (is_last),
		.no_factor    (no_factor)
	);

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for trial_division_factorizer: directed table, then random values.
module tb;
	import tdf_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] factor;
		logic [NW-1:0]    index;
		logic             last;
		logic             none;
	} factor_rec_t;

	typedef struct packed {
		logic [IN_W-1:0]  value;
		logic             typed;
		logic [OUT_W-1:0] factor;
		logic [NW-1:0]    index;
		logic             last;
		logic             none;
	} probe_t;

	localparam int PROBES = 21;
	localparam int RANDOM_ITEMS = 80;
	localparam int HOLD_CYCLES = 400;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [IN_W-1:0]  value = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [OUT_W-1:0] factor;
	logic [NW-1:0]    factor_index;
	logic             is_last;
	logic             no_factor;

	factor_rec_t factors_due [$];
	factor_rec_t head;
	int          mismatches = 0;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;

	// typed rows: zero, one and primes; the rest go through the predictor
	probe_t probe_table [PROBES] = '{
		{32'd0,          1'b1, 32'd0,       6'd0, 1'b1, 1'b1},
		{32'd1,          1'b1, 32'd0,       6'd0, 1'b1, 1'b1},
		{32'd2,          1'b1, 32'd2,       6'd1, 1'b1, 1'b0},
		{32'd3,          1'b1, 32'd3,       6'd1, 1'b1, 1'b0},
		{32'd4,          1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd6,          1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd8,          1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd9,          1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd10,         1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd49,         1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd63001,      1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd65521,      1'b1, 32'd65521,   6'd1, 1'b1, 1'b0},
		{32'd131042,     1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'h0000_FFFF,  1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'hFFFF_0000,  1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'hFFFF_FC00,  1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'h8000_0000,  1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'hC000_0000,  1'b0, 32'd0,       6'd0, 1'b0, 1'b0},
		{32'd1000003,    1'b1, 32'd1000003, 6'd1, 1'b1, 1'b0},
		{32'd0,          1'b1, 32'd0,       6'd0, 1'b1, 1'b1},
		{32'd1,          1'b1, 32'd0,       6'd0, 1'b1, 1'b1}
	};

	trial_division_factorizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.factor       (factor),
		.factor_index (factor_index),
		.is_last      (is_last),
		.no_factor    (no_factor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic void expect_result(input logic [63:0] f, input int idx,
		input logic last, input logic none);
		factor_rec_t rec;
		rec.factor = f[OUT_W-1:0];
		rec.index = idx[NW-1:0];
		rec.last = last;
		rec.none = none;
		factors_due.push_back(rec);
	endfunction

	function automatic void predict_factors(input logic [IN_W-1:0] raw);
		logic [63:0] v;
		logic [63:0] rest;
		logic [63:0] cand;
		logic [63:0] primes [$];
		int i;
		v = 64'(raw) & ((64'd1 << DW) - 64'd1);
		if (v <= 64'd1) begin
			expect_result(64'd0, 0, 1'b1, 1'b1);
			return;
		end
		rest = v;
		for (cand = 64'(FIRST_CAND); (cand - 1) * (cand - 1) <= v; cand++) begin
			while (rest % cand == 0 && primes.size() < MAX_RESULTS) begin
				primes.push_back(cand);
				rest = rest / cand;
			end
			if (rest <= 64'd1 || primes.size() >= MAX_RESULTS)
				break;
		end
		if (rest > 64'd1 && primes.size() < MAX_RESULTS)
			primes.push_back(rest);
		for (i = 0; i < primes.size(); i++)
			expect_result(primes[i], i + 1, i == primes.size() - 1, 1'b0);
	endfunction

	// mostly cheap values: small, smooth, or small odd part shifted up
	function automatic logic [IN_W-1:0] random_value();
		logic [63:0] acc;
		logic [63:0] mult;
		int pick;
		pick = $urandom_range(0, 99);
		acc = 64'd1;
		if (pick < 25) begin
			acc = 64'($urandom_range(0, 4095));
		end else if (pick < 60) begin
			repeat ($urandom_range(1, 40)) begin
				mult = 64'($urandom_range(2, 40));
				if (acc * mult <= 64'hFFFF_FFFF)
					acc = acc * mult;
			end
		end else if (pick < 85) begin
			acc = 64'($urandom_range(1, 1023)) << $urandom_range(0, 22);
		end else begin
			acc = 64'($urandom_range(0, 1048575));
		end
		return acc[IN_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatches++;
		$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
	endtask

	task automatic offer_value(input logic [IN_W-1:0] v);
		if (!steady && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		int k;
		logic [IN_W-1:0] v;
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (k = 0; k < PROBES; k++) begin
			offer_value(probe_table[k].value);
			if (probe_table[k].typed)
				expect_result(64'(probe_table[k].factor), int'(probe_table[k].index),
					probe_table[k].last, probe_table[k].none);
			else
				predict_factors(probe_table[k].value);
		end
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 15)
				hold_req = 1'b1;
			steady = (k >= 30 && k < 55);
			if (k == 65) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (factors_due.size() != 0);
			end
			v = random_value();
			offer_value(v);
			predict_factors(v);
		end
		in_valid <= 1'b0;
		steady = 1'b0;
		while (factors_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && factors_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// result side: random stalls, one long hold while items keep coming
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (factors_due.size() == 0) begin
				report_mismatch("unexpected item, factor", 64'd0, 64'(factor));
			end else begin
				head = factors_due.pop_front();
				if (factor !== head.factor)
					report_mismatch("factor", 64'(head.factor), 64'(factor));
				if (factor_index !== head.index)
					report_mismatch("factor_index", 64'(head.index), 64'(factor_index));
				if (is_last !== head.last)
					report_mismatch("is_last", 64'(head.last), 64'(is_last));
				if (no_factor !== head.none)
					report_mismatch("no_factor", 64'(head.none), 64'(no_factor));
			end
		end
	end

endmodule

@@ trial_division_factorizer.f @@
rtl/core/tdf_pkg.sv
rtl/core/tdf_div.sv
rtl/core/tdf_dp.sv
rtl/core/tdf_ctrl.sv
rtl/core/trial_division_factorizer.sv
sim/tb.sv
